// File: sv/stti_pkg.sv
package stti_pkg;

	// table size
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] key;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] entry_value;
		logic [3:0]         entry_index;
		logic [4:0]         stored_count;
		logic               last;
	} rsp_item_t;

	// datapath operations issued by the controller
	typedef enum logic [2:0] {
		DP_NOP,
		DP_CAPTURE,
		DP_INSERT,
		DP_DELETE,
		DP_DUMP,
		DP_EMPTY
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic rsp_free;
		logic table_empty;
		logic dump_last;
	} dp_stat_t;

endpackage

// File: sv/stti_datapath.sv
module stti_datapath import stti_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            dp_cmd,
	input  logic signed [31:0] key,
	output dp_stat_t           dp_stat,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_item_t          rsp
);

	logic signed [31:0] cells_q [CAPACITY];
	logic [CNT_W-1:0]   count_q;
	logic signed [31:0] key_q;
	logic [CAPACITY-1:0] ge_q;
	logic [CAPACITY-1:0] eq_q;
	logic [IDX_W-1:0]   dump_idx_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	logic [IDX_W-1:0]   ins_pos;
	logic [IDX_W-1:0]   del_pos;
	logic               found;
	logic               full;
	logic               rsp_free;
	logic [CNT_W-1:0]   count_dec;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign found     = |eq_q;
	assign count_dec = count_q - CNT_W'(1);

	// insert position: first stored key not below the new one, else the end
	always_comb begin
		ins_pos = count_q[IDX_W-1:0];
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (ge_q[i]) begin
				ins_pos = IDX_W'(i);
			end
		end
	end

	// delete position: first stored key equal to the operand
	always_comb begin
		del_pos = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (eq_q[i]) begin
				del_pos = IDX_W'(i);
			end
		end
	end

	assign dp_stat.rsp_free    = rsp_free;
	assign dp_stat.table_empty = (count_q == '0);
	assign dp_stat.dump_last   = ({1'b0, dump_idx_q} == count_dec);

	// operand capture: every cell compares against the key at once
	always_ff @(posedge clk) begin
		if (dp_cmd.op == DP_CAPTURE) begin
			key_q <= key;
			for (int i = 0; i < CAPACITY; i++) begin
				ge_q[i] <= (CNT_W'(i) < count_q) && (cells_q[i] >= key);
				eq_q[i] <= (CNT_W'(i) < count_q) && (cells_q[i] == key);
			end
		end
	end

	// cell array: shift up on insert, shift down on delete
	always_ff @(posedge clk) begin
		if (dp_cmd.op == DP_INSERT && !full) begin
			for (int j = 0; j < CAPACITY; j++) begin
				if (IDX_W'(j) == ins_pos) begin
					cells_q[j] <= key_q;
				end else if (j > 0 && IDX_W'(j) > ins_pos) begin
					cells_q[j] <= cells_q[(j > 0) ? j - 1 : 0];
				end
			end
		end else if (dp_cmd.op == DP_DELETE && found) begin
			for (int j = 0; j < CAPACITY - 1; j++) begin
				if (IDX_W'(j) >= del_pos) begin
					cells_q[j] <= cells_q[j + 1];
				end
			end
		end
	end

	// entry count and dump pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			dump_idx_q <= '0;
		end else begin
			unique case (dp_cmd.op)
				DP_CAPTURE: dump_idx_q <= '0;
				DP_INSERT: begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				DP_DELETE: begin
					if (found) begin
						count_q <= count_dec;
					end
				end
				DP_DUMP:  dump_idx_q <= dump_idx_q + IDX_W'(1);
				default: ;
			endcase
		end
	end

	// response register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (dp_cmd.op == DP_INSERT || dp_cmd.op == DP_DELETE
				|| dp_cmd.op == DP_DUMP || dp_cmd.op == DP_EMPTY) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response register payload
	always_ff @(posedge clk) begin
		unique case (dp_cmd.op)
			DP_INSERT: begin
				rsp_q.entry_value <= key_q;
				rsp_q.last        <= 1'b1;
				if (full) begin
					rsp_q.status       <= ST_FULL;
					rsp_q.entry_index  <= '0;
					rsp_q.stored_count <= 5'(count_q);
				end else begin
					rsp_q.status       <= ST_OK;
					rsp_q.entry_index  <= 4'(ins_pos);
					rsp_q.stored_count <= 5'(count_q + CNT_W'(1));
				end
			end
			DP_DELETE: begin
				rsp_q.entry_value <= key_q;
				rsp_q.last        <= 1'b1;
				if (found) begin
					rsp_q.status       <= ST_OK;
					rsp_q.entry_index  <= 4'(del_pos);
					rsp_q.stored_count <= 5'(count_dec);
				end else begin
					rsp_q.status       <= ST_NOT_FOUND;
					rsp_q.entry_index  <= '0;
					rsp_q.stored_count <= 5'(count_q);
				end
			end
			DP_DUMP: begin
				rsp_q.status       <= ST_OK;
				rsp_q.entry_value  <= cells_q[dump_idx_q];
				rsp_q.entry_index  <= 4'(dump_idx_q);
				rsp_q.stored_count <= 5'(count_q);
				rsp_q.last         <= dp_stat.dump_last;
			end
			DP_EMPTY: begin
				rsp_q.status       <= ST_EMPTY;
				rsp_q.entry_value  <= '0;
				rsp_q.entry_index  <= '0;
				rsp_q.stored_count <= '0;
				rsp_q.last         <= 1'b1;
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: sv/stti_ctrl.sv
module stti_ctrl import stti_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic [1:0] command,
	output logic       cmd_stall,
	input  dp_stat_t   dp_stat,
	output dp_cmd_t    dp_cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_DELETE,
		S_DUMP,
		S_EMPTY
	} state_t;

	state_t state_q;

	assign cmd_stall = (state_q != S_IDLE);

	// datapath operation for this cycle
	always_comb begin
		dp_cmd.op = DP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					dp_cmd.op = DP_CAPTURE;
				end
			end
			S_INSERT: begin
				if (dp_stat.rsp_free) begin
					dp_cmd.op = DP_INSERT;
				end
			end
			S_DELETE: begin
				if (dp_stat.rsp_free) begin
					dp_cmd.op = DP_DELETE;
				end
			end
			S_DUMP: begin
				if (dp_stat.rsp_free) begin
					dp_cmd.op = DP_DUMP;
				end
			end
			S_EMPTY: begin
				if (dp_stat.rsp_free) begin
					dp_cmd.op = DP_EMPTY;
				end
			end
			default: ;
		endcase
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (command)
							CMD_INSERT: state_q <= S_INSERT;
							CMD_DELETE: state_q <= S_DELETE;
							CMD_DUMP: begin
								state_q <= dp_stat.table_empty ? S_EMPTY : S_DUMP;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_INSERT, S_DELETE, S_EMPTY: begin
					if (dp_stat.rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DUMP: begin
					if (dp_stat.rsp_free && dp_stat.dump_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/sorted_table_insert_delete_core.sv
// channel  direction  payload      handshake
// cmd      in         cmd_item_t   cmd_valid / cmd_stall
// rsp      out        rsp_item_t   rsp_valid / rsp_stall
//
// insert and delete: the transfer, in which all 16 cells compare against the key
// in parallel into registered flags, then a step that shifts the cells; a dump reads
// one cell per cycle through the dump pointer while the response register is free,
// giving N responses for N stored keys, and a dump of an empty table gives one ST_EMPTY response.
// arst_n clears the entry count and the control state; cell contents are not reset.
// a stalled response register holds the controller in place until its transfer.
module sorted_table_insert_delete_core import stti_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// sequencing
	stti_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (cmd.command),
		.cmd_stall (cmd_stall),
		.dp_stat   (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	// key cells and response register
	stti_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd),
		.key       (cmd.key),
		.dp_stat   (dp_stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// File: tb/sv/tb_sorted_table_insert_delete_core.sv
module tb_sorted_table_insert_delete_core;
	import stti_pkg::*;

	// command value that the block must ignore
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// predicted table contents and the responses still owed by the block
	logic signed [31:0] model_keys [CAPACITY];
	int                 model_count = 0;
	rsp_item_t          expected_rsp_q [$];

	int mismatch_count = 0;
	int hold_len = 0;
	bit quiet = 1'b0;

	sorted_table_insert_delete_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// generous overall limit
	initial begin
		#(64'd8_000_000);
		$display("** sorted_table_insert_delete_core: FAILED **");
		$finish;
	end

	function automatic void push_expected(input logic [1:0] st, input logic signed [31:0] val,
			input int idx, input int cnt, input logic lst);
		rsp_item_t r;
		r.status       = st;
		r.entry_value  = val;
		r.entry_index  = idx[3:0];
		r.stored_count = cnt[4:0];
		r.last         = lst;
		expected_rsp_q.push_back(r);
	endfunction

	// apply one accepted command to the predicted table and queue its responses
	function automatic void predict_table_op(input cmd_item_t c);
		int pos;
		int j;
		case (c.command)
			CMD_INSERT: begin
				if (model_count >= CAPACITY) begin
					push_expected(ST_FULL, c.key, 0, model_count, 1'b1);
				end else begin
					// goes in front of the first key that is greater or equal
					pos = 0;
					while (pos < model_count && model_keys[pos] < c.key)
						pos++;
					for (j = model_count; j > pos; j--)
						model_keys[j] = model_keys[j - 1];
					model_keys[pos] = c.key;
					model_count++;
					push_expected(ST_OK, c.key, pos, model_count, 1'b1);
				end
			end
			CMD_DELETE: begin
				pos = 0;
				while (pos < model_count && model_keys[pos] != c.key)
					pos++;
				if (pos < model_count) begin
					for (j = pos; j + 1 < model_count; j++)
						model_keys[j] = model_keys[j + 1];
					model_count--;
					push_expected(ST_OK, c.key, pos, model_count, 1'b1);
				end else begin
					push_expected(ST_NOT_FOUND, c.key, 0, model_count, 1'b1);
				end
			end
			CMD_DUMP: begin
				if (model_count == 0)
					push_expected(ST_EMPTY, 32'sd0, 0, 0, 1'b1);
				for (j = 0; j < model_count; j++)
					push_expected(ST_OK, model_keys[j], j, model_count, j == model_count - 1);
			end
			default: ;
		endcase
	endfunction

	// key source: stored keys, a small cluster, extremes or the full range
	function automatic logic signed [31:0] pick_key(input int hit_pct);
		if (model_count > 0 && $urandom_range(99) < hit_pct)
			return model_keys[$urandom_range(model_count - 1)];
		case ($urandom_range(3))
			0: return $signed($urandom_range(8)) - 32'sd4;
			1: begin
				case ($urandom_range(3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// offer one command, wait for its transfer, then maybe idle
	task automatic send_cmd(input logic [1:0] op, input logic signed [31:0] key);
		cmd_item_t item;
		item.command = op;
		item.key     = key;
		cmd       <= item;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		predict_table_op(item);
		if (!quiet && $urandom_range(99) < 10) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// stop offering and wait until every owed response has arrived
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_rsp(input rsp_item_t exp, input rsp_item_t got);
		if (got.status !== exp.status) begin
			$error("status: expected %0d, got %0d", exp.status, got.status);
			mismatch_count++;
		end
		if (got.entry_value !== exp.entry_value) begin
			$error("entry_value: expected %0d, got %0d", exp.entry_value, got.entry_value);
			mismatch_count++;
		end
		if (got.entry_index !== exp.entry_index) begin
			$error("entry_index: expected %0d, got %0d", exp.entry_index, got.entry_index);
			mismatch_count++;
		end
		if (got.stored_count !== exp.stored_count) begin
			$error("stored_count: expected %0d, got %0d", exp.stored_count, got.stored_count);
			mismatch_count++;
		end
		if (got.last !== exp.last) begin
			$error("last: expected %0d, got %0d", exp.last, got.last);
			mismatch_count++;
		end
	endtask

	// response side: check each transfer, then choose the next stall
	always @(posedge clk) begin : rsp_side
		rsp_item_t exp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				$error("unexpected response: status %0d value %0d", rsp.status, rsp.entry_value);
				mismatch_count++;
			end else begin
				exp = expected_rsp_q.pop_front();
				compare_rsp(exp, rsp);
			end
		end
		if (hold_len > 0) begin
			rsp_stall <= 1'b1;
			hold_len--;
		end else if (!quiet && $urandom_range(99) < 10) begin
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// extremes, duplicates, head and tail deletes, empty and ignored commands
	task automatic test_directed_cases();
		send_cmd(CMD_DUMP, 32'sd0);
		send_cmd(CMD_DELETE, 32'sd7);
		send_cmd(CMD_UNUSED, -32'sd1);
		send_cmd(CMD_INSERT, 32'sd0);
		send_cmd(CMD_INSERT, 32'sh7fffffff);
		send_cmd(CMD_INSERT, 32'sh80000000);
		send_cmd(CMD_INSERT, -32'sd1);
		send_cmd(CMD_INSERT, 32'sd1);
		send_cmd(CMD_INSERT, 32'sd5);
		send_cmd(CMD_INSERT, 32'sd5);
		send_cmd(CMD_INSERT, 32'sh80000000);
		send_cmd(CMD_DUMP, -32'sd1);
		send_cmd(CMD_DELETE, 32'sh80000000);
		send_cmd(CMD_DELETE, 32'sh7fffffff);
		send_cmd(CMD_DELETE, 32'sd5);
		send_cmd(CMD_DELETE, 32'sd42);
		send_cmd(CMD_UNUSED, 32'sh12345678);
		send_cmd(CMD_DUMP, 32'sd0);
		send_cmd(CMD_DELETE, 32'sd5);
		send_cmd(CMD_DELETE, 32'sh80000000);
		send_cmd(CMD_DELETE, -32'sd1);
		send_cmd(CMD_DELETE, 32'sd0);
		send_cmd(CMD_DELETE, 32'sd1);
		send_cmd(CMD_DUMP, 32'sh7fffffff);
	endtask

	// fill to capacity, overflow, full dump, then delete at both ends
	task automatic test_fill_and_overflow();
		while (model_count < CAPACITY)
			send_cmd(CMD_INSERT, pick_key(15));
		send_cmd(CMD_INSERT, pick_key(0));
		send_cmd(CMD_INSERT, pick_key(50));
		send_cmd(CMD_DUMP, $urandom);
		send_cmd(CMD_DELETE, model_keys[0]);
		send_cmd(CMD_DELETE, model_keys[model_count - 1]);
		send_cmd(CMD_DUMP, $urandom);
	endtask

	// receiver holds off while dumps, inserts and deletes keep coming
	task automatic test_backpressure();
		int n;
		hold_len = 300;
		for (n = 0; n < 30; n++) begin
			if (n % 4 == 0)
				send_cmd(CMD_DUMP, $urandom);
			else
				send_cmd(n % 3 == 0 ? CMD_DELETE : CMD_INSERT, pick_key(40));
		end
		wait_drained();
	endtask

	// random mix, phases leaning towards filling, draining or balance
	task automatic test_random_mix(input int n_items);
		int sent;
		int bias;
		int roll;
		int ins_pct;
		logic [1:0] op;
		sent = 0;
		while (sent < n_items) begin
			bias = (sent / 40) % 3;
			ins_pct = (bias == 0) ? 80 : (bias == 1) ? 35 : 58;
			quiet = (sent >= 120 && sent < 180);
			roll = $urandom_range(99);
			if (roll < 3)
				op = CMD_UNUSED;
			else if (roll < 15)
				op = CMD_DUMP;
			else if (roll < ins_pct)
				op = CMD_INSERT;
			else
				op = CMD_DELETE;
			send_cmd(op, pick_key(op == CMD_DELETE ? 60 : 20));
			if (op != CMD_UNUSED)
				sent++;
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_fill_and_overflow();
		test_backpressure();
		test_random_mix(300);
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("** sorted_table_insert_delete_core: PASSED **");
		else
			$display("** sorted_table_insert_delete_core: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
sv/stti_pkg.sv
sv/stti_datapath.sv
sv/stti_ctrl.sv
sv/sorted_table_insert_delete_core.sv
tb/sv/tb_sorted_table_insert_delete_core.sv
